>>> design/ses_pkg.sv
// Shared types, constants and helpers for the Sobel edge stream block.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package ses_pkg;

  // Line store sizing
  localparam int MAX_LINE    = 2048;
  localparam int STORE_DEPTH = 2048;
  localparam int LINE_AW     = $clog2(STORE_DEPTH);
  localparam int WIDTH_CAP   = (MAX_LINE < STORE_DEPTH) ? MAX_LINE : STORE_DEPTH;
  localparam int HEIGHT_CAP  = 4096;
  localparam int DIM_MIN     = 3;

  // Field widths
  localparam int PIX_W   = 8;
  localparam int WIDTH_W = 12;
  localparam int HEIGHT_W = 13;
  localparam int POSX_W  = 11;
  localparam int POSY_W  = 12;
  localparam int CFG_DW  = 13;
  localparam int CFG_AW  = 1;

  // Register indexes
  localparam logic [CFG_AW-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_AW-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 12'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd480;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  // Gray reciprocal: floor(s/3) == (s*683)>>11 for s <= 765
  localparam int GRAY_MUL   = 683;
  localparam int GRAY_SHIFT = 11;

  // One pixel as it leaves the front end
  typedef struct packed {
    logic [PIX_W-1:0]   gray;
    logic [LINE_AW-1:0] addr;
    logic [POSX_W-1:0]  pos_x;
    logic [POSY_W-1:0]  pos_y;
    logic               emit;
    logic               last;
  } pix_t;

  function automatic logic [PIX_W-1:0] gray_of(input logic [PIX_W-1:0] r,
                                               input logic [PIX_W-1:0] g,
                                               input logic [PIX_W-1:0] b);
    logic [9:0]  sum;
    logic [19:0] prod;
    sum  = 10'(r) + 10'(g) + 10'(b);
    prod = 20'(sum) * 20'(GRAY_MUL);
    return prod[GRAY_SHIFT +: PIX_W];
  endfunction

endpackage

>>> design/ses_line_mem.sv
// Dual line store: one synchronous RAM holding rows y-2 and y-1 per column.
// Depends on ses_pkg.
`timescale 1ns / 1ps

module ses_line_mem (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [ses_pkg::LINE_AW-1:0]   rd_addr,
  output logic [2*ses_pkg::PIX_W-1:0]   rd_data_r,
  input  logic                          wr_en,
  input  logic [ses_pkg::LINE_AW-1:0]   wr_addr,
  input  logic [2*ses_pkg::PIX_W-1:0]   wr_data
);

  // {upper, middle}
  logic [2*ses_pkg::PIX_W-1:0] mem [ses_pkg::STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

>>> design/ses_front.sv
// Front end: config registers, raster counters, gray conversion and flags.
// Depends on ses_pkg.
`timescale 1ns / 1ps

module ses_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ses_pkg::CFG_AW-1:0]    cfg_index,
  input  logic [ses_pkg::CFG_DW-1:0]    cfg_wdata,
  input  logic                          advance,
  input  logic [ses_pkg::PIX_W-1:0]     red,
  input  logic [ses_pkg::PIX_W-1:0]     green,
  input  logic [ses_pkg::PIX_W-1:0]     blue,
  output ses_pkg::pix_t                 pix
);

  logic [ses_pkg::WIDTH_W-1:0]  width_r;
  logic [ses_pkg::HEIGHT_W-1:0] height_r;
  logic [ses_pkg::POSX_W-1:0]   col_r, col_nxt;
  logic [ses_pkg::POSY_W-1:0]   row_r, row_nxt;
  logic [ses_pkg::WIDTH_W-1:0]  eff_w;
  logic [ses_pkg::HEIGHT_W-1:0] eff_h;
  logic [ses_pkg::WIDTH_W-1:0]  col_ext, col_inc;
  logic [ses_pkg::HEIGHT_W-1:0] row_ext, row_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= ses_pkg::WIDTH_RST;
      height_r <= ses_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ses_pkg::CFG_IMAGE_WIDTH:  width_r  <= cfg_wdata[ses_pkg::WIDTH_W-1:0];
        ses_pkg::CFG_IMAGE_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamp to the supported frame size
  always_comb begin
    if (width_r < ses_pkg::WIDTH_W'(ses_pkg::DIM_MIN)) begin
      eff_w = ses_pkg::WIDTH_W'(ses_pkg::DIM_MIN);
    end else if (width_r > ses_pkg::WIDTH_W'(ses_pkg::WIDTH_CAP)) begin
      eff_w = ses_pkg::WIDTH_W'(ses_pkg::WIDTH_CAP);
    end else begin
      eff_w = width_r;
    end
    if (height_r < ses_pkg::HEIGHT_W'(ses_pkg::DIM_MIN)) begin
      eff_h = ses_pkg::HEIGHT_W'(ses_pkg::DIM_MIN);
    end else if (height_r > ses_pkg::HEIGHT_W'(ses_pkg::HEIGHT_CAP)) begin
      eff_h = ses_pkg::HEIGHT_W'(ses_pkg::HEIGHT_CAP);
    end else begin
      eff_h = height_r;
    end
  end

  assign col_ext = ses_pkg::WIDTH_W'(col_r);
  assign row_ext = ses_pkg::HEIGHT_W'(row_r);
  assign col_inc = col_ext + ses_pkg::WIDTH_W'(1);
  assign row_inc = row_ext + ses_pkg::HEIGHT_W'(1);

  always_comb begin
    col_nxt = col_inc[ses_pkg::POSX_W-1:0];
    row_nxt = row_r;
    if (col_inc >= eff_w) begin
      col_nxt = '0;
      row_nxt = (row_inc >= eff_h) ? '0 : row_inc[ses_pkg::POSY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (advance) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_comb begin
    pix.gray  = ses_pkg::gray_of(red, green, blue);
    pix.addr  = col_r[ses_pkg::LINE_AW-1:0];
    pix.pos_x = col_r - ses_pkg::POSX_W'(1);
    pix.pos_y = row_r - ses_pkg::POSY_W'(1);
    pix.emit  = (col_r >= ses_pkg::POSX_W'(2)) && (row_r >= ses_pkg::POSY_W'(2))
                && (col_ext < eff_w) && (row_ext < eff_h);
    pix.last  = (col_ext == eff_w - ses_pkg::WIDTH_W'(1))
                && (row_ext == eff_h - ses_pkg::HEIGHT_W'(1));
  end

endmodule

>>> design/ses_kernel.sv
// 3x3 window columns and Sobel magnitude with inversion.
// Depends on ses_pkg.
`timescale 1ns / 1ps

module ses_kernel (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      shift,
  input  logic [ses_pkg::PIX_W-1:0] cur_top,
  input  logic [ses_pkg::PIX_W-1:0] cur_mid,
  input  logic [ses_pkg::PIX_W-1:0] cur_bot,
  output logic [ses_pkg::PIX_W-1:0] edge_val
);

  // [0..2] left column top/mid/bot, [3..5] middle column
  logic [ses_pkg::PIX_W-1:0] win_r [6];

  logic [10:0]        gx_pos, gx_neg, gy_pos, gy_neg;
  logic signed [11:0] gx, gy;
  logic [10:0]        ax, ay;
  logic [11:0]        mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (shift) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= cur_top;
      win_r[4] <= cur_mid;
      win_r[5] <= cur_bot;
    end
  end

  always_comb begin
    gx_pos = 11'(cur_top) + {2'b0, cur_mid, 1'b0} + 11'(cur_bot);
    gx_neg = 11'(win_r[0]) + {2'b0, win_r[1], 1'b0} + 11'(win_r[2]);
    gy_pos = 11'(win_r[0]) + {2'b0, win_r[3], 1'b0} + 11'(cur_top);
    gy_neg = 11'(win_r[2]) + {2'b0, win_r[5], 1'b0} + 11'(cur_bot);
    gx = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
    gy = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
    ax = gx[11] ? 11'(-gx) : 11'(gx);
    ay = gy[11] ? 11'(-gy) : 11'(gy);
    mag = 12'(ax) + 12'(ay);
    edge_val = (mag > 12'(ses_pkg::PIX_MAX)) ? '0 : ses_pkg::PIX_MAX - mag[7:0];
  end

endmodule

>>> design/sobel_edge_stream_top.sv
// Sobel edge stream top level. Depends on ses_pkg, ses_front, ses_line_mem, ses_kernel.
// Each accepted pixel is registered in stage 1, its result (if any) in the output register.
// Throughput: one pixel per cycle sustained; the line store RAM (one read, one write
//   port per cycle) sets it unless out_stall holds; only interior pixels ever wait on it.
// Reset (rst_n, synchronous): sizes 640x480, counters, window and pipeline cleared. The
//   line store is not cleared; the first two rows of a frame rewrite it before it is used.
`timescale 1ns / 1ps

module sobel_edge_stream_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_we,
  input  logic [ses_pkg::CFG_AW-1:0]    cfg_index,
  input  logic [ses_pkg::CFG_DW-1:0]    cfg_wdata,
  // pixel input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ses_pkg::PIX_W-1:0]     in_red,
  input  logic [ses_pkg::PIX_W-1:0]     in_green,
  input  logic [ses_pkg::PIX_W-1:0]     in_blue,
  // result output
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ses_pkg::POSX_W-1:0]    out_pos_x,
  output logic [ses_pkg::POSY_W-1:0]    out_pos_y,
  output logic [ses_pkg::PIX_W-1:0]     out_edge_value,
  output logic                          out_frame_last
);

  // Pipeline:
  //   stage 0: counters, gray, emit flags; RAM read issued for this column.
  //   stage 1: RAM data back (rows y-2 / y-1), Sobel on window + current column,
  //            RAM write-back of the shifted column, window shift.
  //   stage 2: output register.
  // A column address is written when its pixel leaves stage 1 and read again only
  // a full row later (width >= 3), so no forwarding is needed.

  ses_pkg::pix_t              pix;
  ses_pkg::pix_t              s1_r;
  logic                       s1_valid_r, s1_valid_nxt;
  logic                       in_accept, s1_adv, out_free;
  logic [2*ses_pkg::PIX_W-1:0] rd_data;
  logic [ses_pkg::PIX_W-1:0]  cur_top, cur_mid, edge_val;
  logic                       out_valid_r, out_valid_nxt;
  logic [ses_pkg::POSX_W-1:0] out_pos_x_r;
  logic [ses_pkg::POSY_W-1:0] out_pos_y_r;
  logic [ses_pkg::PIX_W-1:0]  out_edge_r;
  logic                       out_last_r;

  // Handshake. Border pixels never wait on the output; interior ones wait
  // only while the output register holds an untaken transaction.
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_adv    = s1_valid_r && (!s1_r.emit || out_free);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  ses_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .advance   (in_accept),
    .red       (in_red),
    .green     (in_green),
    .blue      (in_blue),
    .pix       (pix)
  );

  ses_line_mem u_line_mem (
    .clk       (clk),
    .rd_en     (in_accept),
    .rd_addr   (pix.addr),
    .rd_data_r (rd_data),
    .wr_en     (s1_adv),
    .wr_addr   (s1_r.addr),
    .wr_data   ({cur_mid, s1_r.gray})
  );

  assign cur_top = rd_data[2*ses_pkg::PIX_W-1:ses_pkg::PIX_W];
  assign cur_mid = rd_data[ses_pkg::PIX_W-1:0];

  ses_kernel u_kernel (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift    (s1_adv),
    .cur_top  (cur_top),
    .cur_mid  (cur_mid),
    .cur_bot  (s1_r.gray),
    .edge_val (edge_val)
  );

  // Stage 1 register
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_r <= pix;
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv && s1_r.emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_r.emit) begin
      out_pos_x_r <= s1_r.pos_x;
      out_pos_y_r <= s1_r.pos_y;
      out_edge_r  <= edge_val;
      out_last_r  <= s1_r.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pos_x      = out_pos_x_r;
  assign out_pos_y      = out_pos_y_r;
  assign out_edge_value = out_edge_r;
  assign out_frame_last = out_last_r;

endmodule

>>> design/ses_checker.sv
// Port-level checks for the Sobel edge stream top level, plus its bind.
// Depends on ses_pkg and sobel_edge_stream_top.
`timescale 1ns / 1ps

module ses_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [ses_pkg::POSX_W-1:0]    out_pos_x,
  input logic [ses_pkg::POSY_W-1:0]    out_pos_y,
  input logic [ses_pkg::PIX_W-1:0]     out_edge_value,
  input logic                          out_frame_last
);

  // Stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pos_x) && $stable(out_pos_y)
      && $stable(out_edge_value) && $stable(out_frame_last))
    else $error("result changed while stalled");

  // Reset empties the output
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Input back-pressure only comes from a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // Only interior pixels are reported
  a_interior: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pos_x != '0 && out_pos_y != '0)
    else $error("border pixel reported");

endmodule

bind sobel_edge_stream_top ses_checker u_ses_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_pos_x      (out_pos_x),
  .out_pos_y      (out_pos_y),
  .out_edge_value (out_edge_value),
  .out_frame_last (out_frame_last)
);

>>> dv/tb_top.sv
// Self-checking testbench for the Sobel edge stream block: drives RGB raster frames,
// predicts every interior edge result and checks the result stream in order.
// Depends on ses_pkg and sobel_edge_stream_top.
`timescale 1ns / 1ps

module tb_top;

  // Run control
  localparam int RANDOM_PIXELS = 330;   // stimulus budget of the random frames
  localparam int WIDE_RUN      = 120;   // pixels sent into the first row of a capped width
  localparam int TALL_ROWS     = 15;    // rows sent under a capped height
  localparam int SETTLE_CYCLES = 8;     // pipeline is two stages deep
  localparam int HOLDOFF_LEN   = 300;   // long receiver stall
  localparam int QUIET_LIMIT   = 4000;  // cycles without any transaction
  localparam int MAX_REPORTS   = 10;

  typedef enum int {PAT_NOISE, PAT_RAMP, PAT_STEP} pattern_t;
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [ses_pkg::POSX_W-1:0] pos_x;
    logic [ses_pkg::POSY_W-1:0] pos_y;
    logic [ses_pkg::PIX_W-1:0]  edge_value;
    logic                       frame_last;
  } edge_result_t;

  // DUT connections; every input starts at a known value
  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_we = 1'b0;
  logic [ses_pkg::CFG_AW-1:0]   cfg_index = ses_pkg::CFG_IMAGE_WIDTH;
  logic [ses_pkg::CFG_DW-1:0]   cfg_wdata = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [ses_pkg::PIX_W-1:0]    in_red = '0;
  logic [ses_pkg::PIX_W-1:0]    in_green = '0;
  logic [ses_pkg::PIX_W-1:0]    in_blue = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [ses_pkg::POSX_W-1:0]   out_pos_x;
  logic [ses_pkg::POSY_W-1:0]   out_pos_y;
  logic [ses_pkg::PIX_W-1:0]    out_edge_value;
  logic                         out_frame_last;

  logic in_fire, out_fire;
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;

  // Mirror of the block: size registers, line stores, 3x3 window, raster position
  logic [ses_pkg::WIDTH_W-1:0]  size_w = ses_pkg::WIDTH_RST;
  logic [ses_pkg::HEIGHT_W-1:0] size_h = ses_pkg::HEIGHT_RST;
  bit [ses_pkg::PIX_W-1:0]      gray_upper [ses_pkg::STORE_DEPTH];
  bit [ses_pkg::PIX_W-1:0]      gray_middle [ses_pkg::STORE_DEPTH];
  bit [ses_pkg::PIX_W-1:0]      win_gray [6];   // column x-2 then x-1; top, middle, bottom
  int                           pred_col = 0;
  int                           pred_row = 0;
  edge_result_t                 edge_expected [$];

  // Pixel pattern knobs, re-rolled per frame
  int ramp_dx = 3, ramp_dy = 2, ramp_off = 0;
  int step_col = 5, step_lo = 40, step_hi = 200;

  int idle_pct = 0;      // sender idle chance per cycle, percent
  int stall_pct = 0;     // receiver stall chance per cycle, percent
  int holdoff_req = 0;   // posted by a test, consumed by the receiver process
  int hold_left = 0;
  int pixels_sent = 0;
  int mismatches = 0;

  sobel_edge_stream_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pos_x      (out_pos_x),
    .out_pos_y      (out_pos_y),
    .out_edge_value (out_edge_value),
    .out_frame_last (out_frame_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction: one accepted pixel transaction in, at most one edge result out.
  // ---------------------------------------------------------------------------
  task automatic sobel_predict(input logic [ses_pkg::PIX_W-1:0] r, g, b);
    int w, h, ix, gray, ct, cm, cb, gx, gy, mag;
    edge_result_t res;
    // Out-of-range sizes clamp to the legal window
    w = int'(size_w);
    if (w < ses_pkg::DIM_MIN) w = ses_pkg::DIM_MIN;
    if (w > ses_pkg::WIDTH_CAP) w = ses_pkg::WIDTH_CAP;
    h = int'(size_h);
    if (h < ses_pkg::DIM_MIN) h = ses_pkg::DIM_MIN;
    if (h > ses_pkg::HEIGHT_CAP) h = ses_pkg::HEIGHT_CAP;
    ix   = pred_col % ses_pkg::STORE_DEPTH;
    gray = (int'(r) + int'(g) + int'(b)) / 3;
    ct   = gray_upper[ix];
    cm   = gray_middle[ix];
    cb   = gray;
    // Neighborhood of (col-1,row-1) is complete once col and row reach 2;
    // positions past a shrunken size give nothing
    if (pred_col >= 2 && pred_row >= 2 && pred_col < w && pred_row < h) begin
      gx  = (ct + 2 * cm + cb) - (win_gray[0] + 2 * win_gray[1] + win_gray[2]);
      gy  = (win_gray[0] + 2 * win_gray[3] + ct) - (win_gray[2] + 2 * win_gray[5] + cb);
      mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
      if (mag > int'(ses_pkg::PIX_MAX)) mag = int'(ses_pkg::PIX_MAX);
      res.pos_x      = ses_pkg::POSX_W'(pred_col - 1);
      res.pos_y      = ses_pkg::POSY_W'(pred_row - 1);
      res.edge_value = ses_pkg::PIX_W'(int'(ses_pkg::PIX_MAX) - mag);
      res.frame_last = (pred_col == w - 1) && (pred_row == h - 1);
      edge_expected.push_back(res);
    end
    win_gray[0] = win_gray[3];
    win_gray[1] = win_gray[4];
    win_gray[2] = win_gray[5];
    win_gray[3] = ses_pkg::PIX_W'(ct);
    win_gray[4] = ses_pkg::PIX_W'(cm);
    win_gray[5] = ses_pkg::PIX_W'(cb);
    gray_upper[ix]  = ses_pkg::PIX_W'(cm);
    gray_middle[ix] = ses_pkg::PIX_W'(cb);
    pred_col++;
    if (pred_col >= w) begin
      pred_col = 0;
      pred_row++;
      if (pred_row >= h) pred_row = 0;
    end
    pred_col = pred_col % (1 << ses_pkg::POSX_W);
    pred_row = pred_row % (1 << ses_pkg::POSY_W);
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Shared send: optional idle cycles, then offer one pixel and hold it until taken.
  task automatic send_rgb(input logic [ses_pkg::PIX_W-1:0] r, g, b);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    do @(posedge clk); while (in_stall);
    sobel_predict(r, g, b);
    pixels_sent++;
  endtask

  function automatic logic [ses_pkg::PIX_W-1:0] jitter(input int level);
    int v;
    v = level + $urandom_range(8) - 4;
    if (v < 0) v = 0;
    if (v > int'(ses_pkg::PIX_MAX)) v = int'(ses_pkg::PIX_MAX);
    return ses_pkg::PIX_W'(v);
  endfunction

  // Ramp and step content follows the raster position the mirror is at; noise is random.
  task automatic send_pixel(input pattern_t pat);
    int level;
    case (pat)
      PAT_NOISE: begin
        send_rgb(ses_pkg::PIX_W'($urandom), ses_pkg::PIX_W'($urandom),
                 ses_pkg::PIX_W'($urandom));
      end
      default: begin
        if (pat == PAT_RAMP)
          level = (pred_col * ramp_dx + pred_row * ramp_dy + ramp_off) % 256;
        else
          level = (pred_col < step_col) ? step_lo : step_hi;
        send_rgb(jitter(level), jitter(level), jitter(level));
      end
    endcase
  endtask

  // Sends until the raster position is back at the origin: a whole frame from
  // the origin, or the rest of one from mid-frame.
  task automatic send_frame(input pattern_t pat);
    ramp_dx  = $urandom_range(12);
    ramp_dy  = $urandom_range(12);
    ramp_off = $urandom_range(255);
    step_col = $urandom_range(2, 20);
    step_lo  = $urandom_range(255);
    step_hi  = $urandom_range(255);
    do send_pixel(pat); while (pred_col != 0 || pred_row != 0);
  endtask

  // Sender pause: drop valid and wait for every outstanding result, plus the
  // pipeline depth for pixels that give none.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (edge_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Both size registers, back to back; only called with the block idle.
  task automatic write_sizes(input int w, input int h);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= ses_pkg::CFG_IMAGE_WIDTH;
    cfg_wdata <= ses_pkg::CFG_DW'(w);
    @(posedge clk);
    size_w = ses_pkg::WIDTH_W'(w);
    @(negedge clk);
    cfg_index <= ses_pkg::CFG_IMAGE_HEIGHT;
    cfg_wdata <= ses_pkg::CFG_DW'(h);
    @(posedge clk);
    size_h = ses_pkg::HEIGHT_W'(h);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin idle_pct = 0;  stall_pct = 0;  end
      IDLE_SENDER:   begin idle_pct = 57; stall_pct = 0;  end
      IDLE_RECEIVER: begin idle_pct = 0;  stall_pct = 57; end
      default:       begin idle_pct = 29; stall_pct = 29; end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a counted hold-off when a test posts one.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (holdoff_req > 0) begin
      hold_left   = holdoff_req;
      holdoff_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: each accepted result against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    edge_result_t want;
    if (rst_n && out_fire) begin
      if (edge_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected edge result: (%0d,%0d) edge=%0d last=%0b",
                   out_pos_x, out_pos_y, out_edge_value, out_frame_last);
      end else begin
        want = edge_expected.pop_front();
        if (out_pos_x !== want.pos_x || out_pos_y !== want.pos_y ||
            out_edge_value !== want.edge_value || out_frame_last !== want.frame_last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("edge mismatch: want (%0d,%0d) e=%0d l=%0b, got (%0d,%0d) e=%0d l=%0b",
                     want.pos_x, want.pos_y, want.edge_value, want.frame_last,
                     out_pos_x, out_pos_y, out_edge_value, out_frame_last);
        end
      end
    end
  end

  // Watchdog: too long without any transaction on either channel means a hang.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || in_fire || out_fire) quiet = 0;
      else quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Three 3x3 frames from size values below the minimum: full-scale vertical
  // edge (magnitude saturates, edge 0), flat white (no edge, 255) and a small
  // ramp down the rows (exact unsaturated magnitude, checks the divide by three).
  task automatic test_smallest_frames();
    logic [ses_pkg::PIX_W-1:0] r, g, b;
    set_idling(IDLE_NONE);
    write_sizes(0, 1);
    for (int f = 0; f < 3; f++) begin
      for (int y = 0; y < 3; y++) begin
        for (int x = 0; x < 3; x++) begin
          case (f)
            0: begin
              r = (x == 0) ? 8'd0 : (x == 2) ? ses_pkg::PIX_MAX : 8'd255;
              g = (x == 2) ? ses_pkg::PIX_MAX : 8'd0;
              b = (x == 2) ? ses_pkg::PIX_MAX : 8'd0;
            end
            1: begin
              r = ses_pkg::PIX_MAX; g = ses_pkg::PIX_MAX; b = ses_pkg::PIX_MAX;
            end
            default: begin
              r = (y == 1) ? 8'd31 : 8'd0;
              g = 8'd0;
              b = (y == 2) ? 8'd62 : 8'd0;
            end
          endcase
          send_rgb(r, g, b);
        end
      end
    end
    wait_drained();
  endtask

  // Widest line: width register beyond the store caps to its depth, so a long
  // first row does not wrap; then the width shrinks under the column counter
  // and the frame finishes narrow.
  task automatic test_widest_frame();
    set_idling(IDLE_BOTH);
    write_sizes(4095, 3);
    repeat (WIDE_RUN) send_pixel(PAT_NOISE);
    wait_drained();
    write_sizes(8, 3);
    send_frame(PAT_NOISE);
    wait_drained();
  endtask

  // Tallest frame: height register beyond the cap, narrowest width; after a
  // stretch of rows the height drops so the frame ends on its last row.
  task automatic test_tallest_frame();
    set_idling(IDLE_SENDER);
    write_sizes(2, 8191);
    repeat (3 * TALL_ROWS) send_pixel(PAT_RAMP);
    wait_drained();
    write_sizes(2, TALL_ROWS + 1);
    send_frame(PAT_RAMP);
    wait_drained();
  endtask

  // Size changes in the middle of a frame: the column, then the row, lies past
  // the new size and wraps; then the width grows again before the frame ends.
  task automatic test_resize_mid_frame();
    set_idling(IDLE_RECEIVER);
    write_sizes(20, 10);
    repeat (5 * 20 + 13) send_pixel(PAT_RAMP);
    wait_drained();
    write_sizes(10, 10);
    repeat (25) send_pixel(PAT_STEP);
    wait_drained();
    write_sizes(10, 4);
    repeat (12) send_pixel(PAT_NOISE);
    wait_drained();
    write_sizes(30, 4);
    send_frame(PAT_RAMP);
    wait_drained();
  endtask

  // Receiver holds off for a long stretch while pixels keep coming, so the
  // block fills and stalls its input; then the sender waits for a full drain
  // in mid-frame before finishing it.
  task automatic test_backpressure();
    set_idling(IDLE_NONE);
    write_sizes(16, 12);
    repeat (40) send_pixel(PAT_STEP);
    holdoff_req = HOLDOFF_LEN;
    repeat (100) send_pixel(PAT_NOISE);
    wait_drained();
    send_frame(PAT_RAMP);
    wait_drained();
  endtask

  // Random frames, mostly small, rotating through the idling modes.
  task automatic test_random_frames();
    int start, frame_idx, w, h;
    start     = pixels_sent;
    frame_idx = 0;
    while (pixels_sent - start < RANDOM_PIXELS) begin
      case ($urandom_range(7))
        0: begin w = $urandom_range(2);       h = $urandom_range(3, 8);  end
        1: begin w = $urandom_range(3, 8);    h = $urandom_range(2);     end
        2: begin w = $urandom_range(64, 100); h = 3;                     end
        default: begin w = $urandom_range(3, 24); h = $urandom_range(3, 10); end
      endcase
      set_idling(idle_mode_t'(frame_idx % 4));
      write_sizes(w, h);
      send_frame(pattern_t'($urandom_range(2)));
      wait_drained();
      frame_idx++;
    end
  endtask

  initial begin
    // Synchronous reset, held low from time zero
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_smallest_frames();
    test_widest_frame();
    test_tallest_frame();
    test_resize_mid_frame();
    test_backpressure();
    test_random_frames();

    // Everything predicted has come back; give stray results a chance to show.
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && edge_expected.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
